// ----- src/umfd_pkg.sv -----
// Shared types and constants for the multi-format Unicode decoder.
`default_nettype none
package umfd_pkg;

   localparam int UMFD_QUEUE_DEPTH = 2;

   localparam logic [2:0] MODE_UTF8    = 3'd0;
   localparam logic [2:0] MODE_UTF16LE = 3'd1;
   localparam logic [2:0] MODE_UTF16BE = 3'd2;
   localparam logic [2:0] MODE_UTF32LE = 3'd3;
   localparam logic [2:0] MODE_UTF32BE = 3'd4;

   localparam logic [20:0] REPL_CHAR = 21'h00003F;
   localparam logic [31:0] MAX_CP    = 32'h0010FFFF;

   typedef struct packed {
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic [7:0] byte3;
      logic [2:0] bytes_available;
   } req_type;

   typedef struct packed {
      logic [20:0] code_point;
      logic [2:0]  bytes_consumed;
   } rsp_type;

   typedef enum logic [1:0] {
      KIND_UTF8  = 2'd0,
      KIND_UTF16 = 2'd1,
      KIND_UTF32 = 2'd2
   } kind_type;

   // data[31:24] is the first unit byte after byte-order normalization
   typedef struct packed {
      kind_type    kind;
      logic [2:0]  count;
      logic [31:0] data;
   } entry_type;

endpackage
`default_nettype wire

// ----- src/umfd_front.sv -----
// Front end: format register, transaction accept and classification.
`default_nettype none
module umfd_front import umfd_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      csr_valid,
   output logic           csr_ready,
   input  wire logic [2:0] csr_data,
   input  wire logic      start,
   output logic           busy,
   input  wire req_type   req_data,
   input  wire logic      queue_full,
   output logic           push,
   output entry_type      push_data
);

   logic [2:0] mode_ff, mode_in;
   logic [2:0] count;

   assign csr_ready = 1'b1;
   assign busy      = queue_full;

   always_comb begin
      mode_in = mode_ff;
      if (csr_valid && csr_ready) begin
         mode_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_UTF8;
      end else begin
         mode_ff <= mode_in;
      end
   end

   assign count = (req_data.bytes_available > 3'd4) ? 3'd4 : req_data.bytes_available;
   // empty windows give no result and are dropped here
   assign push  = start && !busy && (req_data.bytes_available != 3'd0);

   always_comb begin
      push_data.count = count;
      unique case (mode_ff)
         MODE_UTF16LE: begin
            push_data.kind = KIND_UTF16;
            push_data.data = {req_data.byte1, req_data.byte0, req_data.byte3, req_data.byte2};
         end
         MODE_UTF16BE: begin
            push_data.kind = KIND_UTF16;
            push_data.data = {req_data.byte0, req_data.byte1, req_data.byte2, req_data.byte3};
         end
         MODE_UTF32LE: begin
            push_data.kind = KIND_UTF32;
            push_data.data = {req_data.byte3, req_data.byte2, req_data.byte1, req_data.byte0};
         end
         MODE_UTF32BE: begin
            push_data.kind = KIND_UTF32;
            push_data.data = {req_data.byte0, req_data.byte1, req_data.byte2, req_data.byte3};
         end
         default: begin
            push_data.kind = KIND_UTF8;
            push_data.data = {req_data.byte0, req_data.byte1, req_data.byte2, req_data.byte3};
         end
      endcase
   end

endmodule
`default_nettype wire

// ----- src/umfd_queue.sv -----
// Short queue between the front and back ends.
`default_nettype none
module umfd_queue import umfd_pkg::*; #(
   parameter int DEPTH = UMFD_QUEUE_DEPTH
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type push_data,
   input  wire logic      pop,
   output logic           full,
   output logic           empty,
   output entry_type      head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   entry_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full    = (count_ff == FULL_COUNT);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ----- src/umfd_back.sv -----
// Back end: decodes one queued window per cycle into a registered result.
`default_nettype none
module umfd_back import umfd_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      empty,
   input  wire entry_type head,
   output logic           pop,
   output logic           strobe,
   output rsp_type        rsp_data
);

   logic        strobe_ff, strobe_in;
   rsp_type     rsp_ff, rsp_in;
   logic [7:0]  b0, b1, b2, b3;
   logic [2:0]  n;
   logic        c1, c2, c3;
   logic [10:0] v2;
   logic [15:0] v3;
   logic [20:0] v4;
   logic [15:0] hi, lo;

   assign pop = !empty;
   assign b0  = head.data[31:24];
   assign b1  = head.data[23:16];
   assign b2  = head.data[15:8];
   assign b3  = head.data[7:0];
   assign n   = head.count;
   assign c1  = (b1[7:6] == 2'b10);
   assign c2  = (b2[7:6] == 2'b10);
   assign c3  = (b3[7:6] == 2'b10);
   assign v2  = {b0[4:0], b1[5:0]};
   assign v3  = {b0[3:0], b1[5:0], b2[5:0]};
   assign v4  = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
   assign hi  = head.data[31:16];
   assign lo  = head.data[15:0];

   always_comb begin
      rsp_in.code_point     = {13'd0, b0};
      rsp_in.bytes_consumed = 3'd1;
      unique case (head.kind)
         KIND_UTF16: begin
            if (n < 3'd2) begin
               rsp_in.code_point = REPL_CHAR;
            end else begin
               rsp_in.bytes_consumed = 3'd2;
               rsp_in.code_point     = {5'd0, hi};
               if (hi[15:10] == 6'b110110 && n == 3'd4 && lo[15:10] == 6'b110111) begin
                  rsp_in.code_point     = {1'b0, hi[9:0], lo[9:0]} + 21'h010000;
                  rsp_in.bytes_consumed = 3'd4;
               end
            end
         end
         KIND_UTF32: begin
            if (n < 3'd4) begin
               rsp_in.code_point     = REPL_CHAR;
               rsp_in.bytes_consumed = n;
            end else begin
               rsp_in.bytes_consumed = 3'd4;
               rsp_in.code_point     = (head.data > MAX_CP) ? REPL_CHAR : head.data[20:0];
            end
         end
         KIND_UTF8: begin
            if (b0 <= 8'h7F) begin
               rsp_in.bytes_consumed = 3'd1;
            end else if (b0 <= 8'hDF) begin
               if (n >= 3'd2 && c1 && v2 >= 11'h080) begin
                  rsp_in.code_point     = {10'd0, v2};
                  rsp_in.bytes_consumed = 3'd2;
               end
            end else if (b0 <= 8'hEF) begin
               if (n >= 3'd3 && c1 && c2 && v3 >= 16'h0800) begin
                  rsp_in.code_point     = {5'd0, v3};
                  rsp_in.bytes_consumed = 3'd3;
               end
            end else begin
               if (n == 3'd4 && c1 && c2 && c3 && v4 >= 21'h010000
                   && v4 <= MAX_CP[20:0]) begin
                  rsp_in.code_point     = v4;
                  rsp_in.bytes_consumed = 3'd4;
               end
            end
         end
         default: begin
            rsp_in.code_point     = REPL_CHAR;
            rsp_in.bytes_consumed = 3'd1;
         end
      endcase
      strobe_in = !empty;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign strobe   = strobe_ff;
   assign rsp_data = rsp_ff;

endmodule
`default_nettype wire

// ----- src/unicode_multi_format_decoder_unit.sv -----
// Top level of the multi-format Unicode decoder.
// Decodes one code point from the front of a window of up to four bytes
// in UTF-8, UTF-16LE/BE or UTF-32LE/BE, as set by the format register.
// Input: a transaction is taken at a clock edge with start high and busy
// low; req_data carries the four bytes and the count of valid ones.
// A window with a count of zero is dropped and gives no result.
// Output: strobe is high for one cycle with rsp_data holding the code
// point and the bytes it used. The receiver cannot stall it.
// Config: csr_data is written into the format register when csr_valid
// and csr_ready are high; csr_ready is always high. Write it only idle.
// Path: a taken transaction goes from the front end into the queue, then
// through the back end decode into the output register.
// Throughput: one transaction per cycle; the back end drains one queue
// entry each cycle, so busy stays low in normal operation.
// Reset: synchronous; empties the queue, clears strobe, and sets the
// format to UTF-8.
`default_nettype none
module unicode_multi_format_decoder_unit import umfd_pkg::*; #(
   parameter int QUEUE_DEPTH = UMFD_QUEUE_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [2:0] csr_data,
   input  wire logic       start,
   output logic            busy,
   input  wire req_type    req_data,
   output logic            strobe,
   output rsp_type         rsp_data
);

   logic      push, pop, queue_full, queue_empty;
   entry_type push_data, head;

   umfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   umfd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .full      (queue_full),
      .empty     (queue_empty),
      .head      (head)
   );

   umfd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .empty    (queue_empty),
      .head     (head),
      .pop      (pop),
      .strobe   (strobe),
      .rsp_data (rsp_data)
   );

endmodule
`default_nettype wire

// ----- src/umfd_checker.sv -----
// Port-level assertions for the decoder, bound to the top level.
`default_nettype none
module umfd_checker import umfd_pkg::*; (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire req_type    req_data,
   input wire logic       strobe,
   input wire rsp_type    rsp_data
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !strobe)
      else $error("strobe right after reset");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.bytes_available != 3'd0) |-> ##2 strobe)
      else $error("accepted transaction gave no result");

   a_empty_dropped: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.bytes_available == 3'd0) |-> ##2 !strobe)
      else $error("empty window gave a result");

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      strobe |-> (rsp_data.bytes_consumed != 3'd0 && rsp_data.bytes_consumed <= 3'd4))
      else $error("bytes_consumed out of range");

   a_cp_range: assert property (@(posedge clock) disable iff (reset)
      strobe |-> (rsp_data.code_point <= 21'h10FFFF))
      else $error("code point out of range");

endmodule

bind unicode_multi_format_decoder_unit umfd_checker u_umfd_checker (
   .clock    (clock),
   .reset    (reset),
   .start    (start),
   .busy     (busy),
   .req_data (req_data),
   .strobe   (strobe),
   .rsp_data (rsp_data)
);
`default_nettype wire
